@@ rtl/cpcr_pkg.sv @@
// Shared types and fixed field widths for the circle pair collision resolver.
// No dependencies; the front, the back, the top level and the bench import this package.
`timescale 1ns / 1ps
`default_nettype none

package cpcr_pkg;

	localparam int CTR_W       = 24;  // centre coordinate, signed
	localparam int RAD_W       = 16;  // radius, unsigned
	localparam int WGT_W       = 16;  // weight, unsigned
	localparam int JOLT_W      = 11;  // jolt input, signed Q.F
	localparam int JMV_W       = 12;  // jolt move, room for the negated jolt
	localparam int RSUM_W      = 17;  // radius sum
	localparam int TW_W        = 17;  // total weight
	localparam int OUT_W       = 26;  // move outputs, signed Q.F
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic {
		ACT_BOTH   = 1'b0,
		ACT_STATIC = 1'b1
	} cpcr_act_t;

	// classification handed from front to back
	typedef struct packed {
		logic stat;
		logic near;
	} cpcr_ctl_t;

	// front status towards the top level
	typedef struct packed {
		logic s1_v;
		logic q_full;
		logic q_empty;
	} cpcr_fst_t;

endpackage

`default_nettype wire

@@ rtl/cpcr_root.sv @@
// Pipelined integer square root, one result bit per stage, with a sideband.
// Depends on nothing but the clock and reset; no package content used.
`timescale 1ns / 1ps
`default_nettype none

module cpcr_root #(
	parameter int RW = 26,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [2*RW-2:0]   rad,
	input  logic [SW-1:0]     in_sb,
	output logic              out_v,
	output logic [RW-1:0]     root,
	output logic [SW-1:0]     out_sb
);

	localparam int XW = 2*RW + 1;

	logic [XW-1:0] rem_q [RW];
	logic [RW-1:0] rt_q  [RW];
	logic [SW-1:0] sb_q  [RW];
	logic          v_q   [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stg
		localparam int B = RW - 1 - k;
		logic [XW-1:0] rem_in;
		logic [RW-1:0] rt_in;
		logic [SW-1:0] sb_in;
		logic          v_in;
		logic [XW-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_in = XW'(rad);
			assign rt_in  = '0;
			assign sb_in  = in_sb;
			assign v_in   = in_v;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign rt_in  = rt_q[k-1];
			assign sb_in  = sb_q[k-1];
			assign v_in   = v_q[k-1];
		end

		// (r + 2^B)^2 - r^2
		assign trial = (XW'(rt_in) << (B + 1)) + (XW'(1) << (2*B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_q[k] <= rem_in - trial;
					rt_q[k]  <= rt_in | (RW'(1) << B);
				end else begin
					rem_q[k] <= rem_in;
					rt_q[k]  <= rt_in;
				end
				sb_q[k] <= sb_in;
			end
		end
	end

	assign out_v  = v_q[RW-1];
	assign root   = rt_q[RW-1];
	assign out_sb = sb_q[RW-1];

endmodule

`default_nettype wire

@@ rtl/cpcr_div.sv @@
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Needs num < dvs * 2^QW; no package content used.
`timescale 1ns / 1ps
`default_nettype none

module cpcr_div #(
	parameter int NW = 33,
	parameter int DW = 17,
	parameter int QW = 25,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] dvs,
	input  logic [SW-1:0] in_sb,
	output logic          out_v,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] out_sb
);

	localparam int CW = DW + QW;

	logic [CW-1:0] rem_q [QW];
	logic [DW-1:0] dv_q  [QW];
	logic [QW-1:0] qt_q  [QW];
	logic [SW-1:0] sb_q  [QW];
	logic          v_q   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stg
		localparam int B = QW - 1 - k;
		logic [CW-1:0] rem_in;
		logic [DW-1:0] dv_in;
		logic [QW-1:0] qt_in;
		logic [SW-1:0] sb_in;
		logic          v_in;
		logic [CW-1:0] sh;

		if (k == 0) begin : g_first
			assign rem_in = CW'(num);
			assign dv_in  = dvs;
			assign qt_in  = '0;
			assign sb_in  = in_sb;
			assign v_in   = in_v;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign dv_in  = dv_q[k-1];
			assign qt_in  = qt_q[k-1];
			assign sb_in  = sb_q[k-1];
			assign v_in   = v_q[k-1];
		end

		assign sh = CW'(dv_in) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= sh) begin
					rem_q[k] <= rem_in - sh;
					qt_q[k]  <= qt_in | (QW'(1) << B);
				end else begin
					rem_q[k] <= rem_in;
					qt_q[k]  <= qt_in;
				end
				dv_q[k] <= dv_in;
				sb_q[k] <= sb_in;
			end
		end
	end

	assign out_v  = v_q[QW-1];
	assign quo    = qt_q[QW-1];
	assign out_sb = sb_q[QW-1];

endmodule

`default_nettype wire

@@ rtl/cpcr_front.sv @@
// Front end: applies the jolt, forms the centre difference, classifies the pair
// and holds classified pairs in a short queue. Depends on cpcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpcr_front #(
	parameter int F = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                action,
	input  logic signed [cpcr_pkg::CTR_W-1:0]   center_a_x,
	input  logic signed [cpcr_pkg::CTR_W-1:0]   center_a_y,
	input  logic        [cpcr_pkg::RAD_W-1:0]   radius_a,
	input  logic        [cpcr_pkg::WGT_W-1:0]   weight_a,
	input  logic signed [cpcr_pkg::CTR_W-1:0]   center_b_x,
	input  logic signed [cpcr_pkg::CTR_W-1:0]   center_b_y,
	input  logic        [cpcr_pkg::RAD_W-1:0]   radius_b,
	input  logic        [cpcr_pkg::WGT_W-1:0]   weight_b,
	input  logic signed [cpcr_pkg::JOLT_W-1:0]  jolt_x,
	input  logic signed [cpcr_pkg::JOLT_W-1:0]  jolt_y,
	input  logic                                deq,
	output cpcr_pkg::cpcr_fst_t                 fst,
	output cpcr_pkg::cpcr_ctl_t                 h_ctl,
	output logic                                h_dxn,
	output logic                                h_dyn,
	output logic [cpcr_pkg::RSUM_W+F-1:0]       h_adx,
	output logic [cpcr_pkg::RSUM_W+F-1:0]       h_ady,
	output logic [cpcr_pkg::RSUM_W+F-1:0]       h_sumq,
	output logic [cpcr_pkg::WGT_W-1:0]          h_wa,
	output logic [cpcr_pkg::WGT_W-1:0]          h_wb,
	output logic signed [cpcr_pkg::JMV_W-1:0]   h_jax,
	output logic signed [cpcr_pkg::JMV_W-1:0]   h_jay,
	output logic signed [cpcr_pkg::JMV_W-1:0]   h_jbx,
	output logic signed [cpcr_pkg::JMV_W-1:0]   h_jby
);

	import cpcr_pkg::*;

	localparam int M_W  = RSUM_W + F;
	localparam int DF_W = CTR_W + 2 + F;
	localparam int QP_W = 2 + 2 + 3*M_W + 2*WGT_W + 4*JMV_W;

	logic                     same;
	logic signed [JMV_W-1:0]  jx, jy, jax, jay, jbx, jby;
	logic signed [DF_W-1:0]   dx, dy;
	logic        [DF_W-1:0]   adx, ady;
	logic        [RSUM_W-1:0] rsum;
	logic        [M_W-1:0]    sumq;
	cpcr_ctl_t                ctl;
	logic        [QP_W-1:0]   pk;
	logic        [QP_W-1:0]   pk_s1;
	logic                     v_s1;
	logic        [QP_W-1:0]   mem_q [QUEUE_DEPTH];
	logic        [QPTR_W-1:0] wr_q, rd_q;
	logic        [QPTR_W:0]   cnt_q;
	logic                     q_full, q_empty, q_push, load;

	assign same = (center_a_x == center_b_x) && (center_a_y == center_b_y);
	assign jx   = JMV_W'(jolt_x);
	assign jy   = JMV_W'(jolt_y);

	always_comb begin
		jax = '0;
		jay = '0;
		jbx = '0;
		jby = '0;
		if (same) begin
			if (cpcr_act_t'(action) == ACT_STATIC) begin
				jbx = jx;
				jby = jy;
			end else begin
				jax = jx;
				jay = jy;
				jbx = -jx;
				jby = -jy;
			end
		end
	end

	assign dx = ((DF_W'(center_a_x) - DF_W'(center_b_x)) <<< F) + DF_W'(jax) - DF_W'(jbx);
	assign dy = ((DF_W'(center_a_y) - DF_W'(center_b_y)) <<< F) + DF_W'(jay) - DF_W'(jby);
	assign adx = dx[DF_W-1] ? DF_W'(-dx) : DF_W'(dx);
	assign ady = dy[DF_W-1] ? DF_W'(-dy) : DF_W'(dy);

	assign rsum = RSUM_W'(radius_a) + RSUM_W'(radius_b);
	assign sumq = M_W'(rsum) << F;

	// far apart on either axis: no root needed, no push
	assign ctl.stat = (cpcr_act_t'(action) == ACT_STATIC);
	assign ctl.near = (adx < DF_W'(sumq)) && (ady < DF_W'(sumq));

	assign pk = {ctl, dx[DF_W-1], dy[DF_W-1], adx[M_W-1:0], ady[M_W-1:0], sumq,
		weight_a, weight_b, jax, jay, jbx, jby};

	assign q_full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign q_push  = v_s1 && !q_full;
	assign full    = v_s1 && q_full;
	assign load    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
			end else if (q_push) begin
				v_s1 <= 1'b0;
			end
			if (q_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= rd_q + 1'b1;
			end
			if (q_push && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!q_push && deq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pk_s1 <= pk;
		end
		if (q_push) begin
			mem_q[wr_q] <= pk_s1;
		end
	end

	assign {h_ctl, h_dxn, h_dyn, h_adx, h_ady, h_sumq, h_wa, h_wb,
		h_jax, h_jay, h_jbx, h_jby} = mem_q[rd_q];

	assign fst.s1_v    = v_s1;
	assign fst.q_full  = q_full;
	assign fst.q_empty = q_empty;

endmodule

`default_nettype wire

@@ rtl/cpcr_back.sv @@
// Back end: distance root, push split, unit vector, push products and saturation.
// Depends on cpcr_pkg, cpcr_root and cpcr_div.
`timescale 1ns / 1ps
`default_nettype none

module cpcr_back #(
	parameter int F = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_v,
	input  cpcr_pkg::cpcr_ctl_t                 ctl,
	input  logic                                dxn,
	input  logic                                dyn,
	input  logic [cpcr_pkg::RSUM_W+F-1:0]       adx,
	input  logic [cpcr_pkg::RSUM_W+F-1:0]       ady,
	input  logic [cpcr_pkg::RSUM_W+F-1:0]       sumq,
	input  logic [cpcr_pkg::WGT_W-1:0]          wa,
	input  logic [cpcr_pkg::WGT_W-1:0]          wb,
	input  logic signed [cpcr_pkg::JMV_W-1:0]   jax,
	input  logic signed [cpcr_pkg::JMV_W-1:0]   jay,
	input  logic signed [cpcr_pkg::JMV_W-1:0]   jbx,
	input  logic signed [cpcr_pkg::JMV_W-1:0]   jby,
	output logic                                out_v,
	output logic signed [cpcr_pkg::OUT_W-1:0]   move_a_x,
	output logic signed [cpcr_pkg::OUT_W-1:0]   move_a_y,
	output logic signed [cpcr_pkg::OUT_W-1:0]   move_b_x,
	output logic signed [cpcr_pkg::OUT_W-1:0]   move_b_y,
	output logic                                colliding
);

	import cpcr_pkg::*;

	localparam int M_W   = RSUM_W + F;
	localparam int R_W   = M_W + 1;
	localparam int SQ_W  = 2*M_W;
	localparam int SUM_W = 2*M_W + 1;
	localparam int NN_W  = M_W + F;
	localparam int NS_W  = M_W + WGT_W;
	localparam int NX_W  = F + 2;
	localparam int P_W   = NX_W + M_W + 1;
	localparam int T_W   = P_W - F;
	localparam int SM_W  = T_W + 1;
	localparam int EXT_W = (SM_W > OUT_W) ? SM_W : OUT_W + 1;
	localparam int SB1_W = 4 + 3*M_W + 2*WGT_W + 4*JMV_W;
	localparam int SB3_W = 6 + M_W + 4*JMV_W;
	localparam logic signed [NX_W-1:0] N_ONE = NX_W'(64'd1 << F);

	// stage 1: squares
	logic              v_s1;
	logic [SQ_W-1:0]   sqx_s1, sqy_s1;
	logic [SB1_W-1:0]  sb_s1;
	// stage 2: sum of squares
	logic              v_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic [SB1_W-1:0]  sb_s2;
	// root outputs
	logic              rt_v;
	logic [R_W-1:0]    dlen;
	logic [SB1_W-1:0]  sb_r;
	cpcr_ctl_t         r_ctl;
	logic              r_dxn, r_dyn;
	logic [M_W-1:0]    r_adx, r_ady, r_sumq;
	logic [WGT_W-1:0]  r_wa, r_wb;
	logic [JMV_W-1:0]  r_jax, r_jay, r_jbx, r_jby;
	logic signed [M_W+1:0] o_full;
	logic              hit;
	logic [TW_W-1:0]   tw;
	// stage 3: dividend set-up
	logic              v_s3;
	logic [SB3_W-1:0]  sb_s3;
	logic [NS_W-1:0]   nsa_s3, nsb_s3;
	logic [NN_W-1:0]   nnx_s3, nny_s3;
	logic [TW_W-1:0]   tw_s3;
	logic [R_W-1:0]    dist_s3;
	// divider outputs
	logic              d_v;
	logic [M_W-1:0]    q_nx, q_ny, q_sa, q_sb;
	logic [SB3_W-1:0]  sb_d;
	logic              d_hit, d_stat, d_twz, d_dz, d_dxn, d_dyn;
	logic [M_W-1:0]    d_o;
	logic [JMV_W-1:0]  d_jax, d_jay, d_jbx, d_jby;
	logic signed [NX_W-1:0] nx_mag, ny_mag, nx, ny;
	logic [M_W-1:0]    sa, sb;
	// stage 4: push products
	logic              v_s4;
	logic              hit_s4;
	logic signed [P_W-1:0]   pax_s4, pay_s4, pbx_s4, pby_s4;
	logic signed [JMV_W-1:0] jax_s4, jay_s4, jbx_s4, jby_s4;

	function automatic logic signed [T_W-1:0] trunc_q(input logic signed [P_W-1:0] p);
		logic signed [P_W-1:0] bias;
		logic signed [P_W-1:0] s;
		bias = p[P_W-1] ? P_W'((64'd1 << F) - 64'd1) : '0;
		s    = (p + bias) >>> F;
		return T_W'(s);
	endfunction

	function automatic logic signed [OUT_W-1:0] sat(input logic signed [SM_W-1:0] v);
		logic signed [EXT_W-1:0] e;
		e = EXT_W'(v);
		if (e > EXT_W'(OUT_MAX)) begin
			return OUT_MAX;
		end else if (e < EXT_W'(OUT_MIN)) begin
			return OUT_MIN;
		end
		return OUT_W'(e);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= rt_v;
			v_s4 <= d_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= SQ_W'(adx) * SQ_W'(adx);
			sqy_s1 <= SQ_W'(ady) * SQ_W'(ady);
			sb_s1  <= {ctl, dxn, dyn, adx, ady, sumq, wa, wb, jax, jay, jbx, jby};
			sum_s2 <= SUM_W'(sqx_s1) + SUM_W'(sqy_s1);
			sb_s2  <= sb_s1;
		end
	end

	cpcr_root #(.RW(R_W), .SW(SB1_W)) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s2),
		.rad    (sum_s2),
		.in_sb  (sb_s2),
		.out_v  (rt_v),
		.root   (dlen),
		.out_sb (sb_r)
	);

	assign {r_ctl, r_dxn, r_dyn, r_adx, r_ady, r_sumq, r_wa, r_wb,
		r_jax, r_jay, r_jbx, r_jby} = sb_r;

	// overlap; only a positive overlap on a near pair pushes
	assign o_full = $signed({2'b00, r_sumq}) - $signed({1'b0, dlen});
	assign hit    = r_ctl.near && !o_full[M_W+1] && (o_full != '0);
	assign tw     = TW_W'(r_wa) + TW_W'(r_wb);

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3   <= {hit, r_ctl.stat, (tw == '0), (dlen == '0), r_dxn, r_dyn,
				o_full[M_W-1:0], r_jax, r_jay, r_jbx, r_jby};
			nsa_s3  <= NS_W'(o_full[M_W-1:0]) * NS_W'(r_wb);
			nsb_s3  <= NS_W'(o_full[M_W-1:0]) * NS_W'(r_wa);
			nnx_s3  <= NN_W'(r_adx) << F;
			nny_s3  <= NN_W'(r_ady) << F;
			tw_s3   <= tw;
			dist_s3 <= dlen;
		end
	end

	cpcr_div #(.NW(NN_W), .DW(R_W), .QW(M_W), .SW(SB3_W)) u_div_nx (
		.clk (clk), .arst_n (arst_n), .en (en), .in_v (v_s3),
		.num (nnx_s3), .dvs (dist_s3), .in_sb (sb_s3),
		.out_v (d_v), .quo (q_nx), .out_sb (sb_d)
	);

	cpcr_div #(.NW(NN_W), .DW(R_W), .QW(M_W), .SW(1)) u_div_ny (
		.clk (clk), .arst_n (arst_n), .en (en), .in_v (v_s3),
		.num (nny_s3), .dvs (dist_s3), .in_sb (1'b0),
		.out_v (), .quo (q_ny), .out_sb ()
	);

	cpcr_div #(.NW(NS_W), .DW(TW_W), .QW(M_W), .SW(1)) u_div_sa (
		.clk (clk), .arst_n (arst_n), .en (en), .in_v (v_s3),
		.num (nsa_s3), .dvs (tw_s3), .in_sb (1'b0),
		.out_v (), .quo (q_sa), .out_sb ()
	);

	cpcr_div #(.NW(NS_W), .DW(TW_W), .QW(M_W), .SW(1)) u_div_sb (
		.clk (clk), .arst_n (arst_n), .en (en), .in_v (v_s3),
		.num (nsb_s3), .dvs (tw_s3), .in_sb (1'b0),
		.out_v (), .quo (q_sb), .out_sb ()
	);

	assign {d_hit, d_stat, d_twz, d_dz, d_dxn, d_dyn, d_o,
		d_jax, d_jay, d_jbx, d_jby} = sb_d;

	// unit vector; coincident after the jolt means straight along x
	assign nx_mag = $signed(NX_W'(q_nx));
	assign ny_mag = $signed(NX_W'(q_ny));
	assign nx = d_dz ? N_ONE : (d_dxn ? -nx_mag : nx_mag);
	assign ny = d_dz ? '0 : (d_dyn ? -ny_mag : ny_mag);

	always_comb begin
		priority if (!d_hit) begin
			sa = '0;
			sb = '0;
		end else if (d_stat) begin
			sa = '0;
			sb = d_o;
		end else if (d_twz) begin
			sa = d_o >> 1;
			sb = d_o >> 1;
		end else begin
			sa = q_sa;
			sb = q_sb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pax_s4 <= P_W'(nx) * P_W'($signed({1'b0, sa}));
			pay_s4 <= P_W'(ny) * P_W'($signed({1'b0, sa}));
			pbx_s4 <= P_W'(nx) * P_W'($signed({1'b0, sb}));
			pby_s4 <= P_W'(ny) * P_W'($signed({1'b0, sb}));
			jax_s4 <= $signed(d_jax);
			jay_s4 <= $signed(d_jay);
			jbx_s4 <= $signed(d_jbx);
			jby_s4 <= $signed(d_jby);
			hit_s4 <= d_hit;
		end
	end

	assign out_v     = v_s4;
	assign colliding = hit_s4;
	assign move_a_x  = sat(SM_W'(jax_s4) + SM_W'(trunc_q(pax_s4)));
	assign move_a_y  = sat(SM_W'(jay_s4) + SM_W'(trunc_q(pay_s4)));
	assign move_b_x  = sat(SM_W'(jbx_s4) - SM_W'(trunc_q(pbx_s4)));
	assign move_b_y  = sat(SM_W'(jby_s4) - SM_W'(trunc_q(pby_s4)));

endmodule

`default_nettype wire

@@ rtl/circle_pair_collision_resolve.sv @@
// Circle pair collision resolver: top level with the result register.
// Depends on cpcr_pkg, cpcr_front and cpcr_back.
//
// One candidate pair per cycle is taken in while full is low, and one result per
// pair comes out, in order. The front stage applies the jolt when the centres
// coincide, forms the fixed point centre difference and drops far pairs to a
// no-push result; a four-entry queue then parts it from the back pipeline, which
// takes the integer root of the squared distance (one bit per stage), splits the
// push by weight and normalises the centre line in four restoring dividers (one
// quotient bit per stage), multiplies and saturates. Sustained rate is one pair
// per cycle while pop keeps up. A held result stalls the whole back pipeline as
// one, while the front keeps taking pairs until its queue fills.
`timescale 1ns / 1ps
`default_nettype none

module circle_pair_collision_resolve #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                action,
	input  logic signed [cpcr_pkg::CTR_W-1:0]   center_a_x,
	input  logic signed [cpcr_pkg::CTR_W-1:0]   center_a_y,
	input  logic        [cpcr_pkg::RAD_W-1:0]   radius_a,
	input  logic        [cpcr_pkg::WGT_W-1:0]   weight_a,
	input  logic signed [cpcr_pkg::CTR_W-1:0]   center_b_x,
	input  logic signed [cpcr_pkg::CTR_W-1:0]   center_b_y,
	input  logic        [cpcr_pkg::RAD_W-1:0]   radius_b,
	input  logic        [cpcr_pkg::WGT_W-1:0]   weight_b,
	input  logic signed [cpcr_pkg::JOLT_W-1:0]  jolt_x,
	input  logic signed [cpcr_pkg::JOLT_W-1:0]  jolt_y,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [cpcr_pkg::OUT_W-1:0]   move_a_x,
	output logic signed [cpcr_pkg::OUT_W-1:0]   move_a_y,
	output logic signed [cpcr_pkg::OUT_W-1:0]   move_b_x,
	output logic signed [cpcr_pkg::OUT_W-1:0]   move_b_y,
	output logic                                colliding
);

	import cpcr_pkg::*;

	localparam int F   = FRACTION_BITS;
	localparam int M_W = RSUM_W + F;

	cpcr_fst_t               fst;
	cpcr_ctl_t               h_ctl;
	logic                    h_dxn, h_dyn;
	logic [M_W-1:0]          h_adx, h_ady, h_sumq;
	logic [WGT_W-1:0]        h_wa, h_wb;
	logic signed [JMV_W-1:0] h_jax, h_jay, h_jbx, h_jby;
	logic                    adv, deq;
	logic                    b_v;
	logic signed [OUT_W-1:0] b_ax, b_ay, b_bx, b_by;
	logic                    b_hit;
	logic                    res_v_q;
	logic signed [OUT_W-1:0] res_ax_q, res_ay_q, res_bx_q, res_by_q;
	logic                    res_hit_q;

	// advance the back pipeline whenever the result slot is free or being taken
	assign adv = !res_v_q || pop;
	assign deq = adv && !fst.q_empty;

	cpcr_front #(.F(F)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.center_a_x (center_a_x),
		.center_a_y (center_a_y),
		.radius_a   (radius_a),
		.weight_a   (weight_a),
		.center_b_x (center_b_x),
		.center_b_y (center_b_y),
		.radius_b   (radius_b),
		.weight_b   (weight_b),
		.jolt_x     (jolt_x),
		.jolt_y     (jolt_y),
		.deq        (deq),
		.fst        (fst),
		.h_ctl      (h_ctl),
		.h_dxn      (h_dxn),
		.h_dyn      (h_dyn),
		.h_adx      (h_adx),
		.h_ady      (h_ady),
		.h_sumq     (h_sumq),
		.h_wa       (h_wa),
		.h_wb       (h_wb),
		.h_jax      (h_jax),
		.h_jay      (h_jay),
		.h_jbx      (h_jbx),
		.h_jby      (h_jby)
	);

	cpcr_back #(.F(F)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_v      (!fst.q_empty),
		.ctl       (h_ctl),
		.dxn       (h_dxn),
		.dyn       (h_dyn),
		.adx       (h_adx),
		.ady       (h_ady),
		.sumq      (h_sumq),
		.wa        (h_wa),
		.wb        (h_wb),
		.jax       (h_jax),
		.jay       (h_jay),
		.jbx       (h_jbx),
		.jby       (h_jby),
		.out_v     (b_v),
		.move_a_x  (b_ax),
		.move_a_y  (b_ay),
		.move_b_x  (b_bx),
		.move_b_y  (b_by),
		.colliding (b_hit)
	);

	// result slot: hold while waiting, reload on every advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (adv) begin
			res_v_q <= b_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_ax_q  <= b_ax;
			res_ay_q  <= b_ay;
			res_bx_q  <= b_bx;
			res_by_q  <= b_by;
			res_hit_q <= b_hit;
		end
	end

	assign empty     = !res_v_q;
	assign move_a_x  = res_ax_q;
	assign move_a_y  = res_ay_q;
	assign move_b_x  = res_bx_q;
	assign move_b_y  = res_by_q;
	assign colliding = res_hit_q;

`ifndef SYNTH
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !pop) |=> (res_v_q && $stable(res_ax_q) && $stable(res_bx_q)))
		else $error("waiting result changed while stalled");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && res_v_q && !b_v) |=> empty)
		else $error("result slot not freed after transfer");

	a_full_source: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (fst.q_full && fst.s1_v))
		else $error("full raised with queue space left");

	a_queue_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(fst.q_full && fst.s1_v && adv) |=> !full)
		else $error("queue did not drain on advance");
`endif

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for circle_pair_collision_resolve: a directed table, then random pairs.
// Depends on cpcr_pkg and the block's RTL; the expected moves come from a model of the push maths.
`timescale 1ns / 1ps

module tb;
	import cpcr_pkg::*;

	localparam int FRAC      = 8;
	localparam int N_RANDOM  = 1040;
	localparam int LIMIT     = 400000;
	localparam int DRAIN     = 120;
	localparam int HOLD_LEN  = 400;

	typedef struct {
		cpcr_act_t                 act;
		logic signed [CTR_W-1:0]   ax, ay, bx, by;
		logic        [RAD_W-1:0]   ra, rb;
		logic        [WGT_W-1:0]   wa, wb;
		logic signed [JOLT_W-1:0]  jx, jy;
	} pair_t;

	typedef struct {
		logic signed [OUT_W-1:0] max_, may, mbx, mby;
		logic                    hit;
	} moves_t;

	typedef struct {
		pair_t  p;
		bit     typed;
		moves_t m;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	pair_t cur = '{ACT_BOTH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
	moves_t got;

	moves_t pending_moves[$];
	row_t   plan[$];
	int     mismatches = 0;
	int     cycles = 0;
	int     tx_idle = 0;    // percent of cycles the sender holds off
	int     rx_stall = 0;   // percent of cycles the receiver holds off
	bit     hold_pop = 1'b0;
	bit     start_hold = 1'b0;

	circle_pair_collision_resolve #(.FRACTION_BITS(FRAC)) DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.action(cur.act),
		.center_a_x(cur.ax), .center_a_y(cur.ay), .radius_a(cur.ra), .weight_a(cur.wa),
		.center_b_x(cur.bx), .center_b_y(cur.by), .radius_b(cur.rb), .weight_b(cur.wb),
		.jolt_x(cur.jx), .jolt_y(cur.jy),
		.empty(empty), .pop(pop),
		.move_a_x(got.max_), .move_a_y(got.may), .move_b_x(got.mbx), .move_b_y(got.mby),
		.colliding(got.hit)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clamp_move(longint v);
		if (v > longint'(OUT_MAX)) return longint'(OUT_MAX);
		if (v < longint'(OUT_MIN)) return longint'(OUT_MIN);
		return v;
	endfunction

	// floor(sqrt(s)); the distance stays below 2^26 once far pairs are dropped
	function automatic longint root_floor(longint s);
		longint r, t;
		r = 0;
		for (int b = 26; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= s) r = t;
		end
		return r;
	endfunction

	function automatic moves_t resolve_pair(pair_t p);
		longint one, jax, jay, jbx, jby, pax, pay, pbx, pby;
		longint dx, dy, adx, ady, sumq, dlen, o, nx, ny, sa, sb, tw;
		moves_t m;
		one = longint'(1) << FRAC;
		{jax, jay, jbx, jby, pax, pay, pbx, pby} = '0;
		m.hit = 1'b0;
		if (p.ax == p.bx && p.ay == p.by) begin
			if (p.act == ACT_STATIC) begin
				jbx = p.jx; jby = p.jy;
			end else begin
				jax = p.jx; jay = p.jy; jbx = -longint'(p.jx); jby = -longint'(p.jy);
			end
		end
		dx = (longint'(p.ax) - longint'(p.bx)) * one + jax - jbx;
		dy = (longint'(p.ay) - longint'(p.by)) * one + jay - jby;
		sumq = (longint'(p.ra) + longint'(p.rb)) * one;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		if (adx < sumq && ady < sumq) begin
			dlen = root_floor(adx * adx + ady * ady);
			o = sumq - dlen;
			if (o > 0) begin
				m.hit = 1'b1;
				tw = longint'(p.wa) + longint'(p.wb);
				if (dlen == 0) begin
					nx = one; ny = 0;
				end else begin
					nx = dx * one / dlen;
					ny = dy * one / dlen;
				end
				if (p.act == ACT_STATIC) begin
					sa = 0; sb = o;
				end else if (tw == 0) begin
					sa = o / 2; sb = o / 2;
				end else begin
					sa = o * longint'(p.wb) / tw;
					sb = o * longint'(p.wa) / tw;
				end
				pax = nx * sa / one;
				pay = ny * sa / one;
				pbx = (-nx) * sb / one;
				pby = (-ny) * sb / one;
			end
		end
		m.max_ = OUT_W'(clamp_move(jax + pax));
		m.may  = OUT_W'(clamp_move(jay + pay));
		m.mbx  = OUT_W'(clamp_move(jbx + pbx));
		m.mby  = OUT_W'(clamp_move(jby + pby));
		return m;
	endfunction

	function automatic pair_t mk(cpcr_act_t act, int ax, int ay, int bx, int by,
			int ra, int rb, int wa, int wb, int jx, int jy);
		pair_t p;
		p.act = act; p.ax = CTR_W'(ax); p.ay = CTR_W'(ay);
		p.bx = CTR_W'(bx); p.by = CTR_W'(by);
		p.ra = RAD_W'(ra); p.rb = RAD_W'(rb); p.wa = WGT_W'(wa); p.wb = WGT_W'(wb);
		p.jx = JOLT_W'(jx); p.jy = JOLT_W'(jy);
		return p;
	endfunction

	function automatic moves_t mv(int max_, int may, int mbx, int mby, bit hit);
		moves_t m;
		m.max_ = OUT_W'(max_); m.may = OUT_W'(may); m.mbx = OUT_W'(mbx);
		m.mby = OUT_W'(mby); m.hit = hit;
		return m;
	endfunction

	function automatic row_t typed_row(pair_t p, moves_t m);
		row_t r;
		r.p = p; r.typed = 1'b1; r.m = m;
		return r;
	endfunction

	function automatic row_t model_row(pair_t p);
		row_t r;
		r.p = p; r.typed = 1'b0; r.m = mv(0, 0, 0, 0, 0);
		return r;
	endfunction

	function automatic void add_row(row_t r);
		plan.insert(plan.size(), r);
	endfunction

	// Mostly near pairs with random content, some coincident, some pure noise.
	function automatic pair_t random_pair();
		pair_t p;
		int kind, span;
		p.act = cpcr_act_t'($urandom_range(1));
		p.jx = JOLT_W'($urandom); p.jy = JOLT_W'($urandom);
		if ($urandom_range(9) == 0) begin
			p.wa = '0; p.wb = WGT_W'($urandom_range(3) == 0 ? 0 : $urandom);
		end else begin
			p.wa = WGT_W'($urandom); p.wb = WGT_W'($urandom);
		end
		kind = $urandom_range(99);
		if (kind < 15) begin
			p.ax = CTR_W'($urandom); p.ay = CTR_W'($urandom);
			p.bx = CTR_W'($urandom); p.by = CTR_W'($urandom);
			p.ra = RAD_W'($urandom); p.rb = RAD_W'($urandom);
			return p;
		end
		// small radii most of the time, the full range now and then
		if ($urandom_range(4) == 0) begin
			p.ra = RAD_W'($urandom); p.rb = RAD_W'($urandom);
		end else begin
			p.ra = RAD_W'($urandom_range(300)); p.rb = RAD_W'($urandom_range(300));
		end
		p.ax = CTR_W'(int'($urandom_range(16000000)) - 8000000);
		p.ay = CTR_W'(int'($urandom_range(16000000)) - 8000000);
		if (kind < 35) begin
			p.bx = p.ax; p.by = p.ay;
		end else begin
			span = int'(p.ra) + int'(p.rb) + 2;
			p.bx = CTR_W'(int'(p.ax) + int'($urandom_range(2 * span)) - span);
			p.by = CTR_W'(int'(p.ay) + int'($urandom_range(2 * span)) - span);
		end
		return p;
	endfunction

	// Count the receiver hold-off in its own process so that the queue fills.
	always @(posedge clk) begin
		int left;
		bit done;
		if (start_hold && !done && !hold_pop) begin
			hold_pop <= 1'b1;
			left = HOLD_LEN;
			done = 1'b1;
		end else if (hold_pop) begin
			left = left - 1;
			if (left == 0) hold_pop <= 1'b0;
		end
	end

	// Check each result transfer against the oldest expectation, then choose the next pop.
	always @(posedge clk) begin
		moves_t want;
		if (arst_n && pop && !empty) begin
			if (pending_moves.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
			end else begin
				want = pending_moves.pop_front();
				if (got.max_ !== want.max_ || got.may !== want.may || got.mbx !== want.mbx ||
						got.mby !== want.mby || got.hit !== want.hit) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp a(%0d,%0d) b(%0d,%0d) c%0b got a(%0d,%0d) b(%0d,%0d) c%0b",
							want.max_, want.may, want.mbx, want.mby, want.hit,
							got.max_, got.may, got.mbx, got.mby, got.hit);
				end
			end
		end
		pop <= arst_n && !hold_pop && (int'($urandom_range(99)) >= rx_stall);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("circle_pair_collision_resolve test failed");
			$finish;
		end
	end

	// Idle at random cycle by cycle, then offer one pair and hold it until the transfer.
	task automatic send_pair(row_t r);
		while (int'($urandom_range(99)) < tx_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		cur <= r.p;
		push <= 1'b1;
		do @(posedge clk); while (full);
		pending_moves.insert(pending_moves.size(), r.typed ? r.m : resolve_pair(r.p));
	endtask

	initial begin
		int n;
		add_row(typed_row(mk(ACT_BOTH, -8388608, -8388608, 8388607, 8388607,
			65535, 65535, 65535, 65535, 0, 0), mv(0, 0, 0, 0, 0)));
		add_row(typed_row(mk(ACT_STATIC, 8388607, 8388607, -8388608, 8388607,
			0, 0, 0, 0, 1023, -1024), mv(0, 0, 0, 0, 0)));
		// coincident, zero jolt: unit vector falls back to +x
		add_row(typed_row(mk(ACT_BOTH, 5, -7, 5, -7, 1, 1, 1, 1, 0, 0),
			mv(256, 0, -256, 0, 1)));
		add_row(typed_row(mk(ACT_STATIC, 5, -7, 5, -7, 1, 1, 1, 1, 0, 0),
			mv(0, 0, -512, 0, 1)));
		// zero total weight splits the push evenly
		add_row(typed_row(mk(ACT_BOTH, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0),
			mv(256, 0, -256, 0, 1)));
		// zero radii never overlap; jolt moves remain
		add_row(model_row(mk(ACT_BOTH, 3, 3, 3, 3, 0, 0, 9, 9, 100, -50)));
		// touching exactly is no overlap
		add_row(typed_row(mk(ACT_BOTH, 0, 0, 10, 0, 5, 5, 1, 1, 0, 0),
			mv(0, 0, 0, 0, 0)));
		add_row(model_row(mk(ACT_BOTH, 0, 0, 0, 0, 65535, 65535, 65535, 65535,
			1023, -1024)));
		add_row(model_row(mk(ACT_STATIC, 0, 0, 0, 0, 65535, 65535, 0, 65535,
			-1024, 1023)));
		add_row(model_row(mk(ACT_BOTH, 0, 0, 0, 0, 65535, 65535, 0, 0, 768, -768)));
		add_row(model_row(mk(ACT_STATIC, 8388607, -8388608, 8388607, -8388608,
			65535, 65535, 65535, 0, -768, 768)));
		add_row(model_row(mk(ACT_BOTH, 0, 0, 3, 4, 5, 5, 0, 65535, 0, 0)));
		add_row(model_row(mk(ACT_BOTH, 100, -100, -100, 100, 65535, 65535,
			65535, 65535, 1023, 1023)));
		add_row(model_row(mk(ACT_STATIC, -8388608, 0, -8388608 + 131069, 1,
			65535, 65535, 1, 1, 0, 0)));
		add_row(model_row(mk(ACT_BOTH, -4, 4, 4, -4, 8, 8, 65535, 1, -1, 1)));
		add_row(model_row(mk(ACT_BOTH, 0, 0, 0, 0, 2, 3, 7, 0, 0, -1024)));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) send_pair(plan[i]);

		// Four stretches: none, sender idle, receiver stalling, both.
		for (int ph = 0; ph < 4; ph++) begin
			tx_idle  = (ph == 1) ? 48 : (ph == 3) ? 16 : 0;
			rx_stall = (ph == 2) ? 48 : (ph == 3) ? 16 : 0;
			n = N_RANDOM / 4;
			for (int k = 0; k < n; k++) begin
				if (ph == 0 && k == 40) start_hold = 1'b1;
				send_pair(model_row(random_pair()));
			end
		end
		push <= 1'b0;
		tx_idle = 0;
		rx_stall = 0;

		while (pending_moves.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("circle_pair_collision_resolve test passed");
		else
			$display("circle_pair_collision_resolve test failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cpcr_pkg.sv
rtl/cpcr_root.sv
rtl/cpcr_div.sv
rtl/cpcr_front.sv
rtl/cpcr_back.sv
rtl/circle_pair_collision_resolve.sv
test/tb.sv
